>>> src/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Beat types and shared constants for the register access master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // Width of the bus step counter; only this many low bits of the
  // half period register take effect.
  localparam int unsigned COUNT_BITS = 16;

  // Reset value of the half period register.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd160;

  // Bits in one bus byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Command operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Completion status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NACK = 1'b1;

  // One input beat: a single clock tick of the bus engine.
  typedef struct packed {
    logic        start_cmd;
    logic        operation;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        write_byte_valid;
    logic        sda_in;
  } in_t;

  // One result beat: pin drives and events after that tick.
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] read_byte;
    logic       read_byte_valid;
    logic       write_byte_taken;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } out_t;

endpackage

>>> src/i2crm_engine.sv
// ----------------------------------------------------------------------------
// I2C register access engine
// Bus sequencer that advances by one tick on every step and reports the
// pin drives and transfer events that the tick produces.
// ----------------------------------------------------------------------------
module i2crm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2crm_pkg::in_t    cmd,
  input  logic [15:0]       half_period,
  output i2crm_pkg::out_t   res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_STA1, PH_STA2, PH_WLOW, PH_WHIGH, PH_ALOW, PH_AHIGH, PH_WAITD,
    PH_RLOW, PH_RHIGH, PH_RALOW, PH_RAHIGH, PH_STO1, PH_STO2, PH_STO3
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR, STG_REG, STG_DATA
  } stage_t;

  localparam int unsigned CB = i2crm_pkg::COUNT_BITS;

  phase_t             phase_r, phase_nxt;
  stage_t             stage_r, stage_nxt;
  logic [CB-1:0]      delay_r, delay_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [15:0]        left_r, left_nxt;
  logic [6:0]         dev_r, dev_nxt;
  logic [7:0]         reg_r, reg_nxt;
  logic               op_r, op_nxt;
  logic               rpart_r, rpart_nxt;
  logic               nack_r, nack_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;

  logic [CB-1:0]      lim_raw;
  logic [CB:0]        lim;
  logic [CB:0]        delay_inc;
  logic [3:0]         bit_inc;
  logic [7:0]         got_byte;
  logic               got_valid;
  logic               taken;
  logic               done;
  logic               st;

  // A zero half period counts as a single tick.
  assign lim_raw   = half_period[CB-1:0];
  assign lim       = (lim_raw == '0) ? (CB+1)'(1) : {1'b0, lim_raw};
  assign delay_inc = {1'b0, delay_r} + (CB+1)'(1);
  assign bit_inc   = bit_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    delay_nxt = delay_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    op_nxt    = op_r;
    rpart_nxt = rpart_r;
    nack_nxt  = nack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    got_byte  = 8'd0;
    got_valid = 1'b0;
    taken     = 1'b0;
    done      = 1'b0;
    st        = i2crm_pkg::STATUS_OK;

    if (phase_r == PH_IDLE) begin
      if (cmd.start_cmd) begin
        op_nxt    = cmd.operation;
        dev_nxt   = cmd.device_address;
        reg_nxt   = cmd.register_address;
        left_nxt  = cmd.byte_count;
        rpart_nxt = 1'b0;
        nack_nxt  = 1'b0;
        stage_nxt = STG_ADDR;
        delay_nxt = '0;
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        phase_nxt = PH_STA1;
      end
    end else if (phase_r == PH_WAITD) begin
      // SCL stays low at the byte boundary until the next data byte shows up.
      if (cmd.write_byte_valid) begin
        taken     = 1'b1;
        left_nxt  = left_r - 16'd1;
        delay_nxt = '0;
        shift_nxt = cmd.write_byte;
        bit_nxt   = 4'd0;
        scl_nxt   = 1'b1;
        sda_nxt   = ~cmd.write_byte[7];
        phase_nxt = PH_WLOW;
      end
    end else if (delay_inc < lim) begin
      delay_nxt = delay_inc[CB-1:0];
    end else begin
      delay_nxt = '0;
      case (phase_r)
        PH_STA1: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_STA2;
        end
        PH_STA2: begin
          stage_nxt = STG_ADDR;
          shift_nxt = {dev_r, rpart_r};
          bit_nxt   = 4'd0;
          scl_nxt   = 1'b1;
          sda_nxt   = ~dev_r[6];
          phase_nxt = PH_WLOW;
        end
        PH_WLOW: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_WHIGH;
        end
        PH_WHIGH: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          if (bit_inc < i2crm_pkg::BITS_PER_BYTE) begin
            sda_nxt   = ~shift_r[6];
            phase_nxt = PH_WLOW;
          end else begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_ALOW;
          end
        end
        PH_ALOW: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_AHIGH;
        end
        PH_AHIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
          if (cmd.sda_in) begin
            // Target did not acknowledge: abort through a stop condition.
            nack_nxt  = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_STO1;
          end else if (stage_r == STG_ADDR) begin
            if (rpart_r) begin
              if (left_r == 16'd0) begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_STO1;
              end else begin
                shift_nxt = 8'd0;
                bit_nxt   = 4'd0;
                phase_nxt = PH_RLOW;
              end
            end else begin
              stage_nxt = STG_REG;
              shift_nxt = reg_r;
              bit_nxt   = 4'd0;
              sda_nxt   = ~reg_r[7];
              phase_nxt = PH_WLOW;
            end
          end else if (stage_r == STG_REG && op_r == i2crm_pkg::OP_WRITE &&
                       left_r != 16'd0) begin
            stage_nxt = STG_DATA;
            phase_nxt = PH_WAITD;
          end else if (stage_r == STG_DATA && left_r != 16'd0) begin
            phase_nxt = PH_WAITD;
          end else begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_STO1;
          end
        end
        PH_RLOW: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RHIGH;
        end
        PH_RHIGH: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], cmd.sda_in};
          bit_nxt   = bit_inc;
          if (bit_inc < i2crm_pkg::BITS_PER_BYTE) begin
            phase_nxt = PH_RLOW;
          end else begin
            got_valid = 1'b1;
            got_byte  = {shift_r[6:0], cmd.sda_in};
            left_nxt  = left_r - 16'd1;
            // Acknowledge every byte but the last one.
            sda_nxt   = (left_r != 16'd1);
            phase_nxt = PH_RALOW;
          end
        end
        PH_RALOW: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RAHIGH;
        end
        PH_RAHIGH: begin
          scl_nxt = 1'b1;
          if (left_r != 16'd0) begin
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_RLOW;
          end else begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_STO1;
          end
        end
        PH_STO1: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_STO2;
        end
        PH_STO2: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_STO3;
        end
        PH_STO3: begin
          if (op_r == i2crm_pkg::OP_READ && !rpart_r && !nack_r) begin
            rpart_nxt = 1'b1;
            phase_nxt = PH_STA1;
          end else begin
            done      = 1'b1;
            st        = nack_r ? i2crm_pkg::STATUS_NACK : i2crm_pkg::STATUS_OK;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stage_r <= STG_ADDR;
      delay_r <= '0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      left_r  <= 16'd0;
      dev_r   <= 7'd0;
      reg_r   <= 8'd0;
      op_r    <= 1'b0;
      rpart_r <= 1'b0;
      nack_r  <= 1'b0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      delay_r <= delay_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      op_r    <= op_nxt;
      rpart_r <= rpart_nxt;
      nack_r  <= nack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  always_comb begin
    res.scl_low          = scl_nxt;
    res.sda_low          = sda_nxt;
    res.read_byte        = got_byte;
    res.read_byte_valid  = got_valid;
    res.write_byte_taken = taken;
    res.busy_res         = (phase_nxt != PH_IDLE);
    res.done_res         = done;
    res.status           = st;
  end

endmodule

>>> src/i2c_register_access_master_top.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Tick-driven I2C master that performs register writes and register reads.
// ----------------------------------------------------------------------------
// Every input beat is one tick of the bus engine and produces exactly one
// result beat carrying the SCL and SDA open-drain drives after that tick,
// plus any received byte, write byte consumption and completion status.
// A beat is taken every cycle unless in_stall is raised: the engine state
// and the result register update together on one edge, so the rate is one
// beat per cycle, and a result beat is valid in the cycle after its input
// beat is accepted. The result register is the only buffer; while it holds
// a beat that the downstream side stalls, in_stall is raised. The half
// period register sets how many ticks each bus step lasts (zero acts as
// one), and it should be written only while no transaction is in progress.
module i2c_register_access_master_top (
  input  logic              clk,
  input  logic              rst_n,
  // Input beats: one bus tick each.
  input  logic              in_valid,
  output logic              in_stall,
  input  i2crm_pkg::in_t    in_data,
  // Result beats.
  output logic              out_valid,
  input  logic              out_stall,
  output i2crm_pkg::out_t   out_data,
  // Half period register write port.
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  logic              in_fire;
  logic              out_fire;
  logic [15:0]       half_period_r;
  logic              out_valid_r;
  i2crm_pkg::out_t   out_data_r;
  i2crm_pkg::out_t   step_res;

  // The result register can take a new beat whenever it is empty or its
  // current beat leaves in this same cycle. Nothing is taken during reset.
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2crm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period_r <= cfg_wdata;
    end
  end

  // The engine advances its state only on accepted beats and reports the
  // outcome of the tick combinationally for capture below.
  i2crm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .cmd         (in_data),
    .half_period (half_period_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/i2crm_checker.sv
// ----------------------------------------------------------------------------
// I2C register access master checker
// Port-level assertions on the register access master, bound to the top.
// ----------------------------------------------------------------------------
module i2crm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input i2crm_pkg::out_t   out_data
);

  // An accepted beat always yields a result beat in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result beat");

  // The input side only stalls behind a stalled result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // Completion ends the transaction and status is only flagged with it.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.done_res || out_data.status)) |->
      (out_data.done_res && !out_data.busy_res))
    else $error("status or done seen while still busy");

  // A read byte is zero unless flagged valid.
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.read_byte_valid) |-> (out_data.read_byte == 8'd0))
    else $error("read byte nonzero without valid");

endmodule

bind i2c_register_access_master_top i2crm_checker u_i2crm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/i2c_register_access_master_top_tb.sv
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives bus ticks into the master, plays an I2C target on the data line, and
// checks every result beat against a cycle-accurate model of the sequencer.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top_tb;

  // Cycles without any accepted beat on either channel before the run is
  // declared hung. The longest quiet stretch is the deliberate receiver
  // hold-off plus random stalls around it.
  localparam int WATCHDOG_LIMIT = 2000;

  // Bus step lengths used by the random phases: the fastest setting, then a
  // slower one.
  localparam logic [15:0] HALF_STEPS [2] = '{16'd1, 16'd2};

  // Sequencer phases, in the order of the engine's encoding.
  typedef enum logic [4:0] {
    BUS_IDLE, BUS_STA1, BUS_STA2, BUS_WLOW, BUS_WHIGH, BUS_ALOW, BUS_AHIGH,
    BUS_WAITD, BUS_RLOW, BUS_RHIGH, BUS_RALOW, BUS_RAHIGH, BUS_STO1, BUS_STO2,
    BUS_STO3
  } bus_phase_t;

  // Which byte of the write leg the engine is on.
  localparam logic [1:0] STAGE_ADDR = 2'd0;
  localparam logic [1:0] STAGE_REG  = 2'd1;
  localparam logic [1:0] STAGE_DATA = 2'd2;

  // Result beats that can be read straight off the protocol: nothing going
  // on at all, and the tick on which the final stop completes.
  localparam i2crm_pkg::out_t QUIET     = '0;
  localparam i2crm_pkg::out_t DONE_OK   =
    '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, i2crm_pkg::STATUS_OK};
  localparam i2crm_pkg::out_t DONE_NACK =
    '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, i2crm_pkg::STATUS_NACK};

  // An idle beat with every command field at its top value and start low.
  localparam i2crm_pkg::in_t IDLE_ONES =
    '{1'b0, i2crm_pkg::OP_READ, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1};

  // Directed plan. An idle row is one beat; a transfer row starts a command
  // and keeps ticking until the engine is idle again. Where want_en is set,
  // the last beat of the row is checked against the typed value.
  typedef enum logic {ROW_IDLE, ROW_XFER} row_kind_t;
  typedef struct {
    row_kind_t       kind;
    logic [15:0]     half;
    i2crm_pkg::in_t  beat;
    int              nack;
    logic            want_en;
    i2crm_pkg::out_t want;
  } plan_row_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  i2crm_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  i2crm_pkg::out_t out_data;
  logic            cfg_we    = 1'b0;
  logic [15:0]     cfg_wdata = 16'd0;

  i2c_register_access_master_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Sequencer model. It mirrors the engine's state and is advanced once per
  // accepted input beat, giving the result beat that tick must produce.
  // --------------------------------------------------------------------------
  bus_phase_t  bus_phase  = BUS_IDLE;
  logic [15:0] half_ticks = i2crm_pkg::HALF_PERIOD_RESET;
  logic [15:0] step_cnt   = '0;
  logic [15:0] bytes_rem  = '0;
  logic [3:0]  bit_no     = '0;
  logic [7:0]  shreg      = '0;
  logic [6:0]  dev_q      = '0;
  logic [7:0]  reg_q      = '0;
  logic [1:0]  stage      = STAGE_ADDR;
  logic        op_q       = i2crm_pkg::OP_WRITE;
  logic        read_leg   = 1'b0;
  logic        nacked     = 1'b0;
  logic        scl_drv    = 1'b0;
  logic        sda_drv    = 1'b0;

  // Acknowledge slots completed in the current transaction. The target model
  // answers NACK on slot nack_slot (address, register, then data or the read
  // address), or never when nack_slot is negative.
  int ack_slots = 0;
  int nack_slot = -1;

  function automatic int unsigned step_ticks();
    int unsigned lim;
    lim = 32'(half_ticks) & ((32'd1 << i2crm_pkg::COUNT_BITS) - 32'd1);
    return (lim == 0) ? 32'd1 : lim;
  endfunction

  // Begin shifting out one byte, MSB first; SDA low means a zero bit.
  function automatic void load_octet(input logic [7:0] octet);
    shreg     = octet;
    bit_no    = '0;
    scl_drv   = 1'b1;
    sda_drv   = !octet[7];
    bus_phase = BUS_WLOW;
  endfunction

  function automatic void to_read();
    shreg     = '0;
    bit_no    = '0;
    scl_drv   = 1'b1;
    sda_drv   = 1'b0;
    bus_phase = BUS_RLOW;
  endfunction

  function automatic void to_stop();
    scl_drv   = 1'b1;
    sda_drv   = 1'b1;
    bus_phase = BUS_STO1;
  endfunction

  function automatic i2crm_pkg::out_t advance_bus(input i2crm_pkg::in_t b);
    i2crm_pkg::out_t r;
    r = '0;
    if (bus_phase == BUS_IDLE) begin
      // A command is only latched from idle; while busy it is ignored.
      if (b.start_cmd) begin
        op_q      = b.operation;
        dev_q     = b.device_address;
        reg_q     = b.register_address;
        bytes_rem = b.byte_count;
        read_leg  = 1'b0;
        nacked    = 1'b0;
        stage     = STAGE_ADDR;
        step_cnt  = '0;
        scl_drv   = 1'b0;
        sda_drv   = 1'b0;
        ack_slots = 0;
        bus_phase = BUS_STA1;
      end
    end else if (bus_phase == BUS_WAITD) begin
      // SCL is held low until the next data byte shows up.
      if (b.write_byte_valid) begin
        r.write_byte_taken = 1'b1;
        bytes_rem--;
        step_cnt = '0;
        load_octet(b.write_byte);
      end
    end else if (32'(step_cnt) + 32'd1 < step_ticks()) begin
      step_cnt++;
    end else begin
      step_cnt = '0;
      case (bus_phase)
        BUS_STA1: begin
          sda_drv   = 1'b1;
          bus_phase = BUS_STA2;
        end
        BUS_STA2: begin
          stage = STAGE_ADDR;
          load_octet({dev_q, read_leg});
        end
        BUS_WLOW: begin
          scl_drv   = 1'b0;
          bus_phase = BUS_WHIGH;
        end
        BUS_WHIGH: begin
          scl_drv = 1'b1;
          shreg   = shreg << 1;
          bit_no++;
          if (bit_no < i2crm_pkg::BITS_PER_BYTE) begin
            sda_drv   = !shreg[7];
            bus_phase = BUS_WLOW;
          end else begin
            sda_drv   = 1'b0;
            bus_phase = BUS_ALOW;
          end
        end
        BUS_ALOW: begin
          scl_drv   = 1'b0;
          bus_phase = BUS_AHIGH;
        end
        BUS_AHIGH: begin
          // The acknowledge is sampled on the last tick of the high step.
          ack_slots++;
          scl_drv = 1'b1;
          sda_drv = 1'b0;
          if (b.sda_in) begin
            nacked = 1'b1;
            to_stop();
          end else if (stage == STAGE_ADDR) begin
            if (read_leg) begin
              if (bytes_rem == 16'd0) to_stop();
              else to_read();
            end else begin
              stage = STAGE_REG;
              load_octet(reg_q);
            end
          end else if (stage == STAGE_REG && op_q == i2crm_pkg::OP_WRITE &&
                       bytes_rem != 16'd0) begin
            stage     = STAGE_DATA;
            bus_phase = BUS_WAITD;
          end else if (stage == STAGE_DATA && bytes_rem != 16'd0) begin
            bus_phase = BUS_WAITD;
          end else begin
            to_stop();
          end
        end
        BUS_RLOW: begin
          scl_drv   = 1'b0;
          bus_phase = BUS_RHIGH;
        end
        BUS_RHIGH: begin
          scl_drv = 1'b1;
          shreg   = {shreg[6:0], b.sda_in};
          bit_no++;
          if (bit_no < i2crm_pkg::BITS_PER_BYTE) begin
            bus_phase = BUS_RLOW;
          end else begin
            // ACK every received byte but the last one.
            r.read_byte_valid = 1'b1;
            r.read_byte       = shreg;
            bytes_rem--;
            sda_drv   = (bytes_rem != 16'd0);
            bus_phase = BUS_RALOW;
          end
        end
        BUS_RALOW: begin
          scl_drv   = 1'b0;
          bus_phase = BUS_RAHIGH;
        end
        BUS_RAHIGH: begin
          if (bytes_rem != 16'd0) to_read();
          else to_stop();
        end
        BUS_STO1: begin
          scl_drv   = 1'b0;
          bus_phase = BUS_STO2;
        end
        BUS_STO2: begin
          sda_drv   = 1'b0;
          bus_phase = BUS_STO3;
        end
        BUS_STO3: begin
          // A clean register read goes on to its read leg after the first stop.
          if (op_q == i2crm_pkg::OP_READ && !read_leg && !nacked) begin
            read_leg  = 1'b1;
            bus_phase = BUS_STA1;
          end else begin
            r.done_res = 1'b1;
            r.status   = nacked ? i2crm_pkg::STATUS_NACK : i2crm_pkg::STATUS_OK;
            bus_phase  = BUS_IDLE;
          end
        end
        default: begin
          bus_phase = BUS_IDLE;
          scl_drv   = 1'b0;
          sda_drv   = 1'b0;
        end
      endcase
    end
    r.scl_low  = scl_drv;
    r.sda_low  = sda_drv;
    r.busy_res = (bus_phase != BUS_IDLE);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  i2crm_pkg::out_t expected_q [$];
  int              errors        = 0;
  int              results_seen  = 0;
  logic            offering      = 1'b0;
  logic            steady        = 1'b0;
  logic            pinned        = 1'b0;
  i2crm_pkg::out_t pinned_beat   = '0;
  int              hold_left     = 0;
  logic            pressure_done = 1'b0;
  int              idle_cycles   = 0;

  // A beat with every field random. While the engine is busy this is what
  // the command fields carry, so every bit of them gets toggled.
  function automatic i2crm_pkg::in_t noise_tick();
    i2crm_pkg::in_t b;
    logic [31:0]    w0;
    logic [31:0]    w1;
    w0 = $urandom;
    w1 = $urandom;
    b.start_cmd        = w0[0];
    b.operation        = w0[1];
    b.device_address   = w0[8:2];
    b.register_address = w0[16:9];
    b.write_byte       = w0[24:17];
    b.write_byte_valid = w0[25];
    b.sda_in           = w0[26];
    b.byte_count       = w1[15:0];
    return b;
  endfunction

  // The target side: answer ACK or NACK during acknowledge high steps and
  // offer write data at a byte boundary now and then. Read bits and every
  // other tick keep their random data line level.
  function automatic i2crm_pkg::in_t shape_tick(input i2crm_pkg::in_t b);
    if (bus_phase == BUS_AHIGH) b.sda_in = (ack_slots == nack_slot);
    if (bus_phase == BUS_WAITD) b.write_byte_valid = ($urandom_range(99) < 55);
    return b;
  endfunction

  function automatic i2crm_pkg::in_t cmd_beat(input logic op, input logic [6:0] dev,
                                              input logic [7:0] rg,
                                              input logic [15:0] cnt);
    i2crm_pkg::in_t b;
    b = '0;
    b.start_cmd        = 1'b1;
    b.operation        = op;
    b.device_address   = dev;
    b.register_address = rg;
    b.byte_count       = cnt;
    return b;
  endfunction

  function automatic string beat_text(input i2crm_pkg::out_t b);
    return $sformatf("scl %b sda %b byte %02h rv %b taken %b busy %b done %b st %b",
                     b.scl_low, b.sda_low, b.read_byte, b.read_byte_valid,
                     b.write_byte_taken, b.busy_res, b.done_res, b.status);
  endfunction

  // Offer one beat and wait for it to be taken. The model is advanced at the
  // accepting edge, then the sender may go quiet. Valid is left high when no
  // gap follows, so the caller must either offer the next beat in the same
  // step or call release_input.
  task automatic push_tick(input i2crm_pkg::in_t b);
    i2crm_pkg::out_t got;
    in_data <= b;
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (in_stall);
    got = advance_bus(b);
    if (pinned && !got.busy_res) begin
      got    = pinned_beat;
      pinned = 1'b0;
    end
    expected_q.push_back(got);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        if (offering) begin
          in_valid <= 1'b0;
          offering = 1'b0;
        end
        @(posedge clk);
      end
    end
  endtask

  task automatic release_input();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Start one command and keep ticking until the engine is idle again, or
  // until max_ticks beats have gone in.
  task automatic drive_xfer(input i2crm_pkg::in_t first, input int nack,
                            input int max_ticks, output int ticks);
    nack_slot = nack;
    push_tick(first);
    ticks = 1;
    while (bus_phase != BUS_IDLE && ticks < max_ticks) begin
      push_tick(shape_tick(noise_tick()));
      ticks++;
    end
  endtask

  // Change the bus step length. The engine is idle here; all results are
  // collected first, then the bench lets the last one settle before the write.
  task automatic set_half(input logic [15:0] v);
    release_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    half_ticks = v;
  endtask

  // --------------------------------------------------------------------------
  // Result side: checks each accepted beat against the oldest expectation and
  // decides the stall for the next cycle. Once, after a few hundred results,
  // it holds the channel off for a long stretch while the sender keeps
  // offering, which fills the result register and pushes back on the input.
  // --------------------------------------------------------------------------
  i2crm_pkg::out_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %s", beat_text(out_data));
      end else begin
        want_beat = expected_q.pop_front();
        if (out_data !== want_beat) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %s", beat_text(want_beat));
            $display("  actual   %s", beat_text(out_data));
          end
        end
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!pressure_done && results_seen >= 300) begin
      pressure_done = 1'b1;
      hold_left     = 200;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 36);
    end
  end

  // Hang detector: any accepted beat on either channel clears the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  plan_row_t plan [11];

  initial begin
    int             n;
    int             busy_ticks;
    int             nack;
    int unsigned    cnt;
    i2crm_pkg::in_t b;

    // Directed plan: quiet ticks right after reset, then writes and reads of
    // zero and two bytes at the extremes of the address fields, a zero
    // step length, and a NACK on every kind of acknowledge slot.
    plan = '{
      '{ROW_IDLE, 16'd160, i2crm_pkg::in_t'('0), -1, 1'b1, QUIET},
      '{ROW_IDLE, 16'd160, IDLE_ONES, -1, 1'b1, QUIET},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_WRITE, 7'h00, 8'h00, 16'd0), -1, 1'b1,
        DONE_OK},
      '{ROW_XFER, 16'd0, cmd_beat(i2crm_pkg::OP_WRITE, 7'h7F, 8'hFF, 16'd0), -1, 1'b1,
        DONE_OK},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_WRITE, 7'h55, 8'hAA, 16'd2), -1, 1'b0,
        QUIET},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_READ, 7'h2A, 8'h10, 16'd0), -1, 1'b1,
        DONE_OK},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_READ, 7'h7F, 8'hFF, 16'd2), -1, 1'b0,
        QUIET},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_WRITE, 7'h12, 8'h34, 16'd2), 0, 1'b1,
        DONE_NACK},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_WRITE, 7'h12, 8'h34, 16'd2), 2, 1'b1,
        DONE_NACK},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_READ, 7'h12, 8'h34, 16'd2), 1, 1'b1,
        DONE_NACK},
      '{ROW_XFER, 16'd1, cmd_beat(i2crm_pkg::OP_READ, 7'h12, 8'h34, 16'd2), 2, 1'b1,
        DONE_NACK}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].half != half_ticks) set_half(plan[i].half);
      pinned      = plan[i].want_en;
      pinned_beat = plan[i].want;
      if (plan[i].kind == ROW_IDLE) push_tick(plan[i].beat);
      else drive_xfer(plan[i].beat, plan[i].nack, 1 << 30, n);
    end

    // Random phases: mostly complete transactions with random addresses,
    // short byte counts and the odd NACK, mixed with ignored idle ticks.
    // The second phase runs with no idling on either side.
    foreach (HALF_STEPS[p]) begin
      set_half(HALF_STEPS[p]);
      steady     = (p == 1);
      busy_ticks = 0;
      while (busy_ticks < 40) begin
        if ($urandom_range(99) < 12) begin
          b = noise_tick();
          b.start_cmd = 1'b0;
          push_tick(b);
        end else begin
          b   = noise_tick();
          cnt = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(8, 4);
          b.start_cmd  = 1'b1;
          b.byte_count = cnt[15:0];
          nack = ($urandom_range(99) < 15) ? int'($urandom_range(4)) : -1;
          drive_xfer(b, nack, 1 << 30, n);
          busy_ticks += n;
        end
      end
    end
    steady = 1'b0;

    // Longest step and largest byte count: the engine only gets partway into
    // the start condition, so the run ends with the transfer still going.
    set_half(16'hFFFF);
    drive_xfer(cmd_beat(i2crm_pkg::OP_READ, 7'h7F, 8'hFF, 16'hFFFF), -1, 40, n);

    release_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    errors += expected_q.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
src/i2crm_pkg.sv
src/i2crm_engine.sv
src/i2c_register_access_master_top.sv
src/i2crm_checker.sv
bench/i2c_register_access_master_top_tb.sv
